// ----- sv/psched_pkg.sv -----
// Shared types for the priority FIFO task scheduler.
package psched_pkg;

   typedef enum logic [1:0] {
      ST_NONE       = 2'd0,
      ST_READY      = 2'd1,
      ST_RUNNING    = 2'd2,
      ST_TERMINATED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_CHECK,
      S_DONE
   } state_type;

   localparam logic OP_CREATE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   localparam logic [7:0] SLICE_RESET = 8'd3;

endpackage

// ----- sv/priority_fifo_task_scheduler.sv -----
// Top level of the priority FIFO task scheduler: sequencer, queue state and channels.
//
// Usage:
//   req_ channel carries one item: op (0 create, 1 tick), task_id, priority_req.
//   rsp_ channel returns exactly one result per item, in order.
//   csr_ channel writes slice_length; csr_ready is always high.
// Sequencing:
//   A create passes through S_EXEC and S_DONE to its result.
//   A tick goes the same way when the running task keeps running. When the
//   scheduler must pick a task, it visits levels from the highest down:
//   S_SCAN passes each empty level, and S_CHECK tests each queue head read
//   from the entry memory (registered read), popping terminated heads,
//   until a task is picked or level 0 is passed.
//   One item is processed at a time; req_stall is high while it is at work,
//   and the next transfer can be taken once the sequencer is back in S_IDLE.
// Reset: synchronous; all task states cleared, queues empty, slice_length 3.
// Stall: a finished result holds in the output register while rsp_stall is
//   high; the next item may be taken meanwhile and waits before its result.
module priority_fifo_task_scheduler
   import psched_pkg::*;
#(
   parameter int MAX_TASKS       = 16,
   parameter int PRIORITY_LEVELS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [3:0]  req_task_id,
   input  logic [2:0]  req_priority_req,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_running_valid,
   output logic [3:0]  rsp_running_task,
   output logic        rsp_switched,
   output logic [31:0] rsp_tick_count,
   output logic        rsp_dropped,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_slice_length
);

   localparam int IDW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int PW  = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
   localparam int CW  = $clog2(MAX_TASKS + 1);
   localparam int SW  = IDW + 2;

   state_type      state_ff, state_in;
   logic [7:0]     slice_len_ff;
   status_type     status_ff [MAX_TASKS];
   logic [IDW-1:0] head_ff [PRIORITY_LEVELS];
   logic [CW-1:0]  count_ff [PRIORITY_LEVELS];
   logic           cur_valid_ff, cur_valid_in;
   logic [IDW-1:0] cur_id_ff, cur_id_in;
   logic [7:0]     slice_left_ff, slice_left_in;
   logic [31:0]    ticks_ff, ticks_in;
   logic           op_ff;
   logic [3:0]     id_ff;
   logic [2:0]     prio_ff;
   logic [PW-1:0]  lvl_ff, lvl_in;
   logic           sw_ff, sw_in;
   logic           drop_ff, drop_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_run_ff;
   logic [3:0]     rsp_task_ff;
   logic           rsp_sw_ff;
   logic [31:0]    rsp_ticks_ff;
   logic           rsp_drop_ff;
   logic           rsp_load;

   logic           st_we;
   logic [IDW-1:0] st_wa;
   status_type     st_wd;
   logic           hc_we;
   logic [PW-1:0]  hc_idx;
   logic [IDW-1:0] head_in;
   logic [CW-1:0]  count_in;

   logic           mem_we;
   logic [PW-1:0]  mem_rd_prio;
   logic [IDW-1:0] mem_rd_data;

   logic           req_xfer;
   logic           id_ok, prio_ok;
   logic [IDW-1:0] id_n;
   logic [PW-1:0]  prio_n;
   logic [SW-1:0]  slot_sum;
   logic [IDW-1:0] slot;
   logic [IDW-1:0] lvl_head;
   logic [CW-1:0]  lvl_count;
   logic [IDW-1:0] head_next;
   logic [7:0]     cur_ext;

   assign req_xfer  = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   assign id_ok   = {5'd0, id_ff} < 9'(MAX_TASKS);
   assign prio_ok = {4'd0, prio_ff} < 7'(PRIORITY_LEVELS);
   assign id_n    = IDW'(id_ff);
   assign prio_n  = PW'(prio_ff);

   assign mem_rd_prio = lvl_ff;
   assign lvl_head    = head_ff[(state_ff == S_EXEC) ? prio_n : lvl_ff];
   assign lvl_count   = count_ff[(state_ff == S_EXEC) ? prio_n : lvl_ff];
   assign slot_sum    = SW'(lvl_head) + SW'(lvl_count);
   assign slot        = (slot_sum >= SW'(MAX_TASKS)) ? IDW'(slot_sum - SW'(MAX_TASKS))
                                                     : IDW'(slot_sum);
   assign head_next   = (lvl_head == IDW'(MAX_TASKS - 1)) ? '0 : lvl_head + 1'b1;
   assign cur_ext     = 8'(cur_id_ff);

   psched_entry_mem #(
      .MAX_TASKS       (MAX_TASKS),
      .PRIORITY_LEVELS (PRIORITY_LEVELS)
   ) u_entry_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_prio (prio_n),
      .wr_slot (slot),
      .wr_data (id_n),
      .rd_prio (mem_rd_prio),
      .rd_slot (lvl_head),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      cur_valid_in  = cur_valid_ff;
      cur_id_in     = cur_id_ff;
      slice_left_in = slice_left_ff;
      ticks_in      = ticks_ff;
      lvl_in        = lvl_ff;
      sw_in         = sw_ff;
      drop_in       = drop_ff;
      st_we         = 1'b0;
      st_wa         = id_n;
      st_wd         = ST_READY;
      hc_we         = 1'b0;
      hc_idx        = lvl_ff;
      head_in       = lvl_head;
      count_in      = lvl_count;
      mem_we        = 1'b0;
      rsp_load      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            sw_in   = 1'b0;
            drop_in = 1'b0;
            if (op_ff == OP_CREATE) begin
               state_in = S_DONE;
               if (id_ok && prio_ok) begin
                  if (lvl_count >= CW'(MAX_TASKS)) begin
                     drop_in = 1'b1;
                  end else begin
                     mem_we   = 1'b1;
                     hc_we    = 1'b1;
                     hc_idx   = prio_n;
                     count_in = lvl_count + 1'b1;
                     st_we    = 1'b1;
                     st_wa    = id_n;
                     st_wd    = ST_READY;
                     if (cur_valid_ff && cur_id_ff == id_n) begin
                        slice_left_in = slice_len_ff;
                     end
                  end
               end
            end else begin
               ticks_in = ticks_ff + 32'd1;
               lvl_in   = PW'(PRIORITY_LEVELS - 1);
               if (cur_valid_ff && slice_left_ff > 8'd1) begin
                  slice_left_in = slice_left_ff - 8'd1;
                  state_in      = S_DONE;
               end else begin
                  if (cur_valid_ff) begin
                     slice_left_in = 8'd0;
                     st_we         = 1'b1;
                     st_wa         = cur_id_ff;
                     st_wd         = ST_TERMINATED;
                     cur_valid_in  = 1'b0;
                     cur_id_in     = '0;
                  end
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (lvl_count != '0) begin
               state_in = S_CHECK;
            end else if (lvl_ff == '0) begin
               state_in = S_DONE;
            end else begin
               lvl_in = lvl_ff - 1'b1;
            end
         end
         S_CHECK: begin
            if (status_ff[mem_rd_data] != ST_TERMINATED) begin
               cur_valid_in  = 1'b1;
               cur_id_in     = mem_rd_data;
               slice_left_in = slice_len_ff;
               st_we         = 1'b1;
               st_wa         = mem_rd_data;
               st_wd         = ST_RUNNING;
               sw_in         = 1'b1;
               state_in      = S_DONE;
            end else begin
               hc_we    = 1'b1;
               head_in  = head_next;
               count_in = lvl_count - 1'b1;
               state_in = S_SCAN;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         slice_len_ff  <= SLICE_RESET;
         cur_valid_ff  <= 1'b0;
         cur_id_ff     <= '0;
         slice_left_ff <= 8'd0;
         ticks_ff      <= 32'd0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < MAX_TASKS; i++) begin
            status_ff[i] <= ST_NONE;
         end
         for (int i = 0; i < PRIORITY_LEVELS; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         cur_valid_ff  <= cur_valid_in;
         cur_id_ff     <= cur_id_in;
         slice_left_ff <= slice_left_in;
         ticks_ff      <= ticks_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            slice_len_ff <= csr_slice_length;
         end
         if (st_we) begin
            status_ff[st_wa] <= st_wd;
         end
         if (hc_we) begin
            head_ff[hc_idx]  <= head_in;
            count_ff[hc_idx] <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff   <= req_op;
         id_ff   <= req_task_id;
         prio_ff <= req_priority_req;
      end
      lvl_ff  <= lvl_in;
      sw_ff   <= sw_in;
      drop_ff <= drop_in;
      if (rsp_load) begin
         rsp_run_ff   <= cur_valid_ff;
         rsp_task_ff  <= cur_valid_ff ? cur_ext[3:0] : 4'd0;
         rsp_sw_ff    <= sw_ff;
         rsp_ticks_ff <= ticks_ff;
         rsp_drop_ff  <= drop_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_running_valid = rsp_run_ff;
   assign rsp_running_task  = rsp_task_ff;
   assign rsp_switched      = rsp_sw_ff;
   assign rsp_tick_count    = rsp_ticks_ff;
   assign rsp_dropped       = rsp_drop_ff;

endmodule

// ----- sv/psched_entry_mem.sv -----
// Queue entry memory: one circular buffer of task numbers per priority level.
module psched_entry_mem
   import psched_pkg::*;
#(
   parameter int MAX_TASKS       = 16,
   parameter int PRIORITY_LEVELS = 8,
   localparam int IDW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
   localparam int PW  = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1
) (
   input  logic           clock,
   input  logic           wr_en,
   input  logic [PW-1:0]  wr_prio,
   input  logic [IDW-1:0] wr_slot,
   input  logic [IDW-1:0] wr_data,
   input  logic [PW-1:0]  rd_prio,
   input  logic [IDW-1:0] rd_slot,
   output logic [IDW-1:0] rd_data
);

   logic [IDW-1:0] mem [PRIORITY_LEVELS][MAX_TASKS];
   logic [IDW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_prio][wr_slot] <= wr_data;
      end
      rd_data_ff <= mem[rd_prio][rd_slot];
   end

   assign rd_data = rd_data_ff;

endmodule
